// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, switched off while reset is asserted.
`define CHK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every rising edge, also while reset is asserted.
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/bcpa_pkg.sv -----
// Shared constants, codes and types of the conductivity probe averager.
package bcpa_pkg;

	localparam int ADC_W   = 10;
	localparam int SER_W   = 20;
	localparam int CAL_W   = 32;
	localparam int AVG_W   = 8;
	localparam int CFG_W   = 32;
	localparam int IDX_W   = 2;
	localparam int RES_W   = 32;
	localparam int SUM_W   = 40;
	localparam int SCALE_W = 11;
	localparam int PROD_W  = CAL_W + SCALE_W;
	localparam int DIV_W   = PROD_W + 1;
	localparam int DVS_W   = RES_W;

	localparam int DEF_ADC_BITS = 10;
	localparam int DEF_MAX_AVG  = 255;

	localparam logic [SCALE_W-1:0] EC_SCALE     = 11'd1600;
	localparam logic [SER_W-1:0]   SERIES_R_RST = 20'd5229;
	localparam logic [CAL_W-1:0]   CAL_RST      = 32'd1384000;
	localparam logic [AVG_W-1:0]   AVG_RST      = 8'd100;
	localparam logic [RES_W-1:0]   RES_MAX      = '1;

	typedef enum logic [IDX_W-1:0] {
		REG_SERIES_R = 2'd0,
		REG_CAL      = 2'd1,
		REG_AVG      = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_TAKE,
		OP_MUL_SAMPLE,
		OP_BAD_SAMPLE,
		OP_DIV_START,
		OP_DIV_STORE,
		OP_MEAN,
		OP_MUL_CAL,
		OP_EC_ZERO,
		OP_EMIT
	} dp_op_t;

	typedef enum logic [2:0] {
		SEL_SAMPLE,
		SEL_AVG_T,
		SEL_AVG_B,
		SEL_EC_T,
		SEL_EC_B,
		SEL_EC_M
	} div_sel_t;

	typedef struct packed {
		dp_op_t   op;
		div_sel_t sel;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic bad;
		logic both_full;
		logic div_done;
		logic rt_zero;
		logic rb_zero;
		logic rm_zero;
		logic out_free;
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_S_START,
		ST_S_WAIT,
		ST_WIN_CHK,
		ST_AT_START,
		ST_AT_WAIT,
		ST_AB_START,
		ST_AB_WAIT,
		ST_MEAN,
		ST_CAL,
		ST_ET_START,
		ST_ET_WAIT,
		ST_EB_START,
		ST_EB_WAIT,
		ST_EM_START,
		ST_EM_WAIT,
		ST_OUT
	} state_t;

endpackage

// ----- sv/bcpa_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module bcpa_div import bcpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fits;

	// The dividend shifts out of the top of quo_q while quotient bits enter below.
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1)) && !start;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/bcpa_dp.sv -----
// Datapath: configuration, sample arithmetic, accumulators and result registers.
module bcpa_dp import bcpa_pkg::*; #(
	parameter int ADC_BITS = DEF_ADC_BITS,
	parameter int MAX_AVG  = DEF_MAX_AVG
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  cmd_t             ctl,
	output status_t          sts,
	input  logic             cmd,
	input  logic [ADC_W-1:0] v1_sense,
	input  logic [ADC_W-1:0] v2_sense,
	input  logic [ADC_W-1:0] v_read,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [RES_W-1:0] ec_top,
	output logic [RES_W-1:0] ec_bottom,
	output logic [RES_W-1:0] ec_mean,
	output logic [RES_W-1:0] r_mean,
	output logic             fault
);

	localparam int AW = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
	localparam int SW = AW + 1;

	logic [SER_W-1:0] series_q;
	logic [CAL_W-1:0] cal_q;
	logic [AVG_W-1:0] avg_q;

	logic [SUM_W-1:0] sum_t_q, sum_b_q;
	logic [AVG_W-1:0] cnt_t_q, cnt_b_q;
	logic             fault_q;
	logic             out_valid_q;

	logic                pol_q;
	logic signed [SW-1:0] num_q, den_q;
	logic [AVG_W-1:0]    n_q;
	logic [PROD_W-1:0]   prod_q;
	logic [RES_W-1:0]    rt_q, rb_q, rm_q;
	logic [RES_W-1:0]    ect_q, ecb_q, ecm_q;
	logic [RES_W-1:0]    out_ect_q, out_ecb_q, out_ecm_q, out_rm_q;
	logic                out_fault_q;

	logic signed [SW-1:0] sv1, sv2, svr, raw_num, raw_den, fix_num, fix_den;
	logic [AVG_W-1:0]     n_clamp;
	logic [SER_W+AW-1:0]  smul;
	logic [PROD_W-1:0]    cmul;
	logic [DIV_W-1:0]     dvd;
	logic [DVS_W-1:0]     dvs;
	logic                 div_start;
	logic                 div_done;
	logic [DIV_W-1:0]     quot;
	logic [RES_W-1:0]     q_sat;
	logic [RES_W:0]       rsum;

	// Sign arrangement of the sample: a negative denominator flips both terms.
	always_comb begin
		sv1     = $signed({1'b0, v1_sense[AW-1:0]});
		sv2     = $signed({1'b0, v2_sense[AW-1:0]});
		svr     = $signed({1'b0, v_read[AW-1:0]});
		raw_num = cmd ? (sv2 - svr) : (svr - sv2);
		raw_den = cmd ? (svr - sv1) : (sv1 - svr);
		fix_num = raw_den[SW-1] ? -raw_num : raw_num;
		fix_den = raw_den[SW-1] ? -raw_den : raw_den;
		if (avg_q == '0) begin
			n_clamp = AVG_W'(1);
		end else if (avg_q > AVG_W'(MAX_AVG)) begin
			n_clamp = AVG_W'(MAX_AVG);
		end else begin
			n_clamp = avg_q;
		end
	end

	assign smul = series_q * num_q[AW-1:0];
	assign cmul = cal_q * EC_SCALE;
	assign rsum = {1'b0, rt_q} + {1'b0, rb_q} + (RES_W+1)'(1);

	always_comb begin
		case (ctl.sel)
			SEL_SAMPLE: begin
				dvd = DIV_W'(prod_q) + DIV_W'(den_q[AW-1:0] >> 1);
				dvs = DVS_W'(den_q[AW-1:0]);
			end
			SEL_AVG_T: begin
				dvd = DIV_W'(sum_t_q) + DIV_W'(n_q >> 1);
				dvs = DVS_W'(n_q);
			end
			SEL_AVG_B: begin
				dvd = DIV_W'(sum_b_q) + DIV_W'(n_q >> 1);
				dvs = DVS_W'(n_q);
			end
			SEL_EC_T: begin
				dvd = DIV_W'(prod_q) + DIV_W'(rt_q >> 1);
				dvs = rt_q;
			end
			SEL_EC_B: begin
				dvd = DIV_W'(prod_q) + DIV_W'(rb_q >> 1);
				dvs = rb_q;
			end
			SEL_EC_M: begin
				dvd = DIV_W'(prod_q) + DIV_W'(rm_q >> 1);
				dvs = rm_q;
			end
			default: begin
				dvd = '0;
				dvs = '0;
			end
		endcase
	end

	assign div_start = (ctl.op == OP_DIV_START);

	bcpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quot)
	);

	assign q_sat = (|quot[DIV_W-1:RES_W]) ? RES_MAX : quot[RES_W-1:0];

	// Configuration and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_q    <= SERIES_R_RST;
			cal_q       <= CAL_RST;
			avg_q       <= AVG_RST;
			sum_t_q     <= '0;
			sum_b_q     <= '0;
			cnt_t_q     <= '0;
			cnt_b_q     <= '0;
			fault_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SERIES_R: series_q <= cfg_data[SER_W-1:0];
					REG_CAL:      cal_q    <= cfg_data[CAL_W-1:0];
					REG_AVG:      avg_q    <= cfg_data[AVG_W-1:0];
					default:      ;
				endcase
			end
			// A new word may replace one that is taken at the same edge.
			if (ctl.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (ctl.op)
				OP_BAD_SAMPLE: begin
					fault_q <= 1'b1;
					if (pol_q) begin
						cnt_b_q <= cnt_b_q + AVG_W'(1);
					end else begin
						cnt_t_q <= cnt_t_q + AVG_W'(1);
					end
				end
				OP_DIV_STORE: begin
					if (ctl.sel == SEL_SAMPLE) begin
						if (pol_q) begin
							sum_b_q <= sum_b_q + SUM_W'(q_sat);
							cnt_b_q <= cnt_b_q + AVG_W'(1);
						end else begin
							sum_t_q <= sum_t_q + SUM_W'(q_sat);
							cnt_t_q <= cnt_t_q + AVG_W'(1);
						end
					end
				end
				OP_EC_ZERO: fault_q <= 1'b1;
				OP_EMIT: begin
					sum_t_q <= '0;
					sum_b_q <= '0;
					cnt_t_q <= '0;
					cnt_b_q <= '0;
					fault_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_TAKE: begin
				pol_q <= cmd;
				num_q <= fix_num;
				den_q <= fix_den;
				n_q   <= n_clamp;
			end
			OP_MUL_SAMPLE: prod_q <= PROD_W'(smul);
			OP_MUL_CAL:    prod_q <= cmul;
			OP_MEAN:       rm_q   <= rsum[RES_W:1];
			OP_DIV_STORE: begin
				case (ctl.sel)
					SEL_AVG_T: rt_q  <= q_sat;
					SEL_AVG_B: rb_q  <= q_sat;
					SEL_EC_T:  ect_q <= q_sat;
					SEL_EC_B:  ecb_q <= q_sat;
					SEL_EC_M:  ecm_q <= q_sat;
					default:   ;
				endcase
			end
			OP_EC_ZERO: begin
				case (ctl.sel)
					SEL_EC_T: ect_q <= RES_MAX;
					SEL_EC_B: ecb_q <= RES_MAX;
					SEL_EC_M: ecm_q <= RES_MAX;
					default:  ;
				endcase
			end
			OP_EMIT: begin
				out_ect_q   <= ect_q;
				out_ecb_q   <= ecb_q;
				out_ecm_q   <= ecm_q;
				out_rm_q    <= rm_q;
				out_fault_q <= fault_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.full      = pol_q ? (cnt_b_q >= n_q) : (cnt_t_q >= n_q);
		sts.bad       = (den_q == '0) || num_q[SW-1];
		sts.both_full = (cnt_t_q >= n_q) && (cnt_b_q >= n_q);
		sts.div_done  = div_done;
		sts.rt_zero   = (rt_q == '0);
		sts.rb_zero   = (rb_q == '0);
		sts.rm_zero   = (rm_q == '0);
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign ec_top    = out_ect_q;
	assign ec_bottom = out_ecb_q;
	assign ec_mean   = out_ecm_q;
	assign r_mean    = out_rm_q;
	assign fault     = out_fault_q;

endmodule

// ----- sv/bcpa_ctrl.sv -----
// Controller state machine that sequences the datapath and the shared divider.
module bcpa_ctrl import bcpa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t sts,
	output cmd_t    ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_CHECK;
			ST_CHECK:    state_d = (sts.full || sts.bad) ? ST_WIN_CHK : ST_S_START;
			ST_S_START:  state_d = ST_S_WAIT;
			ST_S_WAIT:   if (sts.div_done) state_d = ST_WIN_CHK;
			ST_WIN_CHK:  state_d = sts.both_full ? ST_AT_START : ST_IDLE;
			ST_AT_START: state_d = ST_AT_WAIT;
			ST_AT_WAIT:  if (sts.div_done) state_d = ST_AB_START;
			ST_AB_START: state_d = ST_AB_WAIT;
			ST_AB_WAIT:  if (sts.div_done) state_d = ST_MEAN;
			ST_MEAN:     state_d = ST_CAL;
			ST_CAL:      state_d = ST_ET_START;
			ST_ET_START: state_d = sts.rt_zero ? ST_EB_START : ST_ET_WAIT;
			ST_ET_WAIT:  if (sts.div_done) state_d = ST_EB_START;
			ST_EB_START: state_d = sts.rb_zero ? ST_EM_START : ST_EB_WAIT;
			ST_EB_WAIT:  if (sts.div_done) state_d = ST_EM_START;
			ST_EM_START: state_d = sts.rm_zero ? ST_OUT : ST_EM_WAIT;
			ST_EM_WAIT:  if (sts.div_done) state_d = ST_OUT;
			ST_OUT:      if (sts.out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ctl.op   = OP_NONE;
		ctl.sel  = SEL_SAMPLE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) ctl.op = OP_TAKE;
			end
			ST_CHECK: begin
				if (sts.full) begin
					ctl.op = OP_NONE;
				end else if (sts.bad) begin
					ctl.op = OP_BAD_SAMPLE;
				end else begin
					ctl.op = OP_MUL_SAMPLE;
				end
			end
			ST_S_START: ctl.op = OP_DIV_START;
			ST_S_WAIT:  if (sts.div_done) ctl.op = OP_DIV_STORE;
			ST_AT_START: begin
				ctl.op  = OP_DIV_START;
				ctl.sel = SEL_AVG_T;
			end
			ST_AT_WAIT: begin
				ctl.sel = SEL_AVG_T;
				if (sts.div_done) ctl.op = OP_DIV_STORE;
			end
			ST_AB_START: begin
				ctl.op  = OP_DIV_START;
				ctl.sel = SEL_AVG_B;
			end
			ST_AB_WAIT: begin
				ctl.sel = SEL_AVG_B;
				if (sts.div_done) ctl.op = OP_DIV_STORE;
			end
			ST_MEAN: ctl.op = OP_MEAN;
			ST_CAL:  ctl.op = OP_MUL_CAL;
			ST_ET_START: begin
				ctl.sel = SEL_EC_T;
				ctl.op  = sts.rt_zero ? OP_EC_ZERO : OP_DIV_START;
			end
			ST_ET_WAIT: begin
				ctl.sel = SEL_EC_T;
				if (sts.div_done) ctl.op = OP_DIV_STORE;
			end
			ST_EB_START: begin
				ctl.sel = SEL_EC_B;
				ctl.op  = sts.rb_zero ? OP_EC_ZERO : OP_DIV_START;
			end
			ST_EB_WAIT: begin
				ctl.sel = SEL_EC_B;
				if (sts.div_done) ctl.op = OP_DIV_STORE;
			end
			ST_EM_START: begin
				ctl.sel = SEL_EC_M;
				ctl.op  = sts.rm_zero ? OP_EC_ZERO : OP_DIV_START;
			end
			ST_EM_WAIT: begin
				ctl.sel = SEL_EC_M;
				if (sts.div_done) ctl.op = OP_DIV_STORE;
			end
			ST_OUT: if (sts.out_free) ctl.op = OP_EMIT;
			default: ;
		endcase
	end

endmodule

// ----- sv/bipolar_conductivity_probe_averager_core.sv -----
// Top level of the bipolar conductivity probe averager.
//
//   Channel  Handshake            Word contents
//   in       in_valid/in_ready    cmd, v1_sense, v2_sense, v_read
//   out      out_valid/out_ready  ec_top, ec_bottom, ec_mean, r_mean, fault
//   cfg      cfg_we               cfg_index, cfg_data (write only)
//
// A word that is accumulated makes one 44-step pass of the divider.
// A word that is ignored or clamped to zero skips the divider.
// The word that completes a window then makes up to five more divider passes.
// Every division but the halving for the mean runs through one shared radix-2 divider.
// Reset clears the accumulators, counts and fault flag and loads the register defaults.
// A waiting result holds in the output register; a new result stalls behind it and holds off new input.
module bipolar_conductivity_probe_averager_core import bcpa_pkg::*; #(
	parameter int ADC_BITS = DEF_ADC_BITS,
	parameter int MAX_AVG  = DEF_MAX_AVG
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  logic [ADC_W-1:0] v1_sense,
	input  logic [ADC_W-1:0] v2_sense,
	input  logic [ADC_W-1:0] v_read,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [RES_W-1:0] ec_top,
	output logic [RES_W-1:0] ec_bottom,
	output logic [RES_W-1:0] ec_mean,
	output logic [RES_W-1:0] r_mean,
	output logic             fault
);

	cmd_t    ctl;
	status_t sts;

	bcpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	bcpa_dp #(
		.ADC_BITS (ADC_BITS),
		.MAX_AVG  (MAX_AVG)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.sts       (sts),
		.cmd       (cmd),
		.v1_sense  (v1_sense),
		.v2_sense  (v2_sense),
		.v_read    (v_read),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ec_top    (ec_top),
		.ec_bottom (ec_bottom),
		.ec_mean   (ec_mean),
		.r_mean    (r_mean),
		.fault     (fault)
	);

endmodule

// ----- sv/bcpa_checker.sv -----
// Port-level checker for the averager core, with its bind statement.
`include "assert_macros.svh"

module bcpa_checker import bcpa_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [RES_W-1:0] ec_top,
	input logic [RES_W-1:0] ec_bottom,
	input logic [RES_W-1:0] ec_mean,
	input logic [RES_W-1:0] r_mean,
	input logic             fault
);

	logic [4*RES_W:0] out_word;

	assign out_word = {ec_top, ec_bottom, ec_mean, r_mean, fault};

	// A result word that is not taken must hold still.
	`CHK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "held word changed")

	// An accepted input word takes the engine out of idle, so two words are never taken back to back.
	`CHK_ASSERT(a_no_back_to_back, in_valid && in_ready |=> !in_ready, "input accepted twice in a row")

	// Without a fault every average is nonzero, so the mean resistance is too.
	`CHK_ASSERT(a_clean_mean, out_valid && !fault |-> r_mean != '0, "zero mean resistance without fault")

	// A new result is only posted from a busy engine.
	`CHK_ASSERT(a_emit_busy, $rose(out_valid) |-> !$past(in_ready), "result posted while engine idle")

	// A clock edge seen in reset leaves no result valid behind it.
	`CHK_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "result valid after reset")

endmodule

bind bipolar_conductivity_probe_averager_core bcpa_checker u_bcpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.ec_top    (ec_top),
	.ec_bottom (ec_bottom),
	.ec_mean   (ec_mean),
	.r_mean    (r_mean),
	.fault     (fault)
);
